>>> rtl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; every other file imports this package.
package u8dec_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int LEN_W    = 3;
    localparam int LEFT_W   = 2;

    localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;

    localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4   = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             bad_lead;
    } u8dec_res_t;

endpackage

>>> rtl/u8dec_if.sv
// Valid/ready channel interfaces for the byte input and the code point output.
// Depends on u8dec_pkg for field widths.
interface u8dec_byte_if
    import u8dec_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8dec_cp_if
    import u8dec_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             bad_lead;

    modport source (output valid, output code_point, output seq_length,
                    output bad_lead, input ready);
    modport sink   (input valid, input code_point, input seq_length,
                    input bad_lead, output ready);
endinterface

>>> rtl/u8dec_in_stage.sv
// Input register of the decoder: holds one accepted byte until the step logic takes it.
// Depends on u8dec_pkg and u8dec_byte_if.
module u8dec_in_stage
    import u8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    u8dec_byte_if.sink        in_chan,
    input  logic              advance,
    output logic              hold_valid,
    output logic [BYTE_W-1:0] hold_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    // The register refills in the same cycle that its item moves on.
    assign in_chan.ready = !valid_reg || advance;
    assign take          = in_chan.valid && in_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_chan.byte_in;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

>>> rtl/u8dec_step.sv
// Sequence state and decode logic: consumes one byte per enabled cycle.
// Depends on u8dec_pkg.
module u8dec_step
    import u8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [BYTE_W-1:0] byte_val,
    output logic              res_valid,
    output u8dec_res_t        res
);

    logic [LEFT_W-1:0] bytes_left_reg;
    logic [LEFT_W-1:0] bytes_left_next;
    logic [CP_W-1:0]   partial_value_reg;
    logic [CP_W-1:0]   partial_value_next;
    logic [LEN_W-1:0]  total_length_reg;
    logic [LEN_W-1:0]  total_length_next;
    logic [CP_W-1:0]   shifted;

    assign shifted = {partial_value_reg[CP_W-7:0], byte_val[5:0]};

    always_comb
    begin
        bytes_left_next    = bytes_left_reg;
        partial_value_next = partial_value_reg;
        total_length_next  = total_length_reg;
        res_valid          = 1'b0;
        res                = '0;
        if (bytes_left_reg != '0)
        begin
            // Any byte inside a sequence counts as a continuation.
            bytes_left_next    = bytes_left_reg - LEFT_W'(1);
            partial_value_next = shifted;
            if (bytes_left_reg == LEFT_W'(1))
            begin
                res_valid          = 1'b1;
                res.code_point     = shifted;
                res.seq_length     = total_length_reg;
                partial_value_next = '0;
                total_length_next  = LEN_BAD;
            end
        end
        else if (byte_val <= ASCII_MAX)
        begin
            res_valid      = 1'b1;
            res.code_point = CP_W'(byte_val);
            res.seq_length = LEN_1;
        end
        else if ((byte_val & LEAD2_MASK) == LEAD2_CODE)
        begin
            partial_value_next = CP_W'(byte_val[4:0]);
            bytes_left_next    = LEFT_W'(1);
            total_length_next  = LEN_2;
        end
        else if ((byte_val & LEAD3_MASK) == LEAD3_CODE)
        begin
            partial_value_next = CP_W'(byte_val[3:0]);
            bytes_left_next    = LEFT_W'(2);
            total_length_next  = LEN_3;
        end
        else if ((byte_val & LEAD4_MASK) == LEAD4_CODE)
        begin
            partial_value_next = CP_W'(byte_val[2:0]);
            bytes_left_next    = LEFT_W'(3);
            total_length_next  = LEN_4;
        end
        else
        begin
            res_valid      = 1'b1;
            res.seq_length = LEN_BAD;
            res.bad_lead   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg    <= '0;
            partial_value_reg <= '0;
            total_length_reg  <= LEN_BAD;
        end
        else if (step_en)
        begin
            bytes_left_reg    <= bytes_left_next;
            partial_value_reg <= partial_value_next;
            total_length_reg  <= total_length_next;
        end
    end

endmodule

>>> rtl/u8dec_out_stage.sv
// Result register of the decoder: holds one finished result until the sink takes it.
// Depends on u8dec_pkg and u8dec_cp_if.
module u8dec_out_stage
    import u8dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  u8dec_res_t  res,
    output logic        can_load,
    u8dec_cp_if.source  out_chan
);

    logic       valid_reg;
    logic       valid_next;
    u8dec_res_t res_reg;

    assign can_load = !valid_reg || out_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_chan.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_chan.valid      = valid_reg;
    assign out_chan.code_point = res_reg.code_point;
    assign out_chan.seq_length = res_reg.seq_length;
    assign out_chan.bad_lead   = res_reg.bad_lead;

endmodule

>>> rtl/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder: one byte per item in, one code point result out per sequence.
// Bytes wait in the input register; results load into the result register as bytes advance.
// Throughput: one byte per cycle unless the result side stalls, set by the single decode step.
// Reset (rst_n low, asynchronous): both stage registers empty, no sequence in progress.
// Depends on u8dec_pkg, u8dec_if, u8dec_in_stage, u8dec_step and u8dec_out_stage.
module utf8_byte_stream_decoder
    import u8dec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    u8dec_byte_if.sink in_chan,
    u8dec_cp_if.source out_chan
);

    // The pipeline has two registers. The input register holds the next byte; the
    // step logic folds it into the sequence state and, when a sequence finishes or
    // a lone byte decodes, writes a result into the output register. Lead bytes and
    // middle bytes of a multi-byte sequence move on without needing the output side.

    logic              hold_valid;
    logic [BYTE_W-1:0] hold_byte;
    logic              res_valid;
    u8dec_res_t        res;
    logic              can_load;
    logic              advance;

    // A held byte advances unless it makes a result and the result register is full.
    assign advance = hold_valid && (!res_valid || can_load);

    u8dec_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_chan    (in_chan),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    u8dec_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .byte_val  (hold_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    u8dec_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .can_load (can_load),
        .out_chan (out_chan)
    );

endmodule
